// File: design/spvm_pkg.sv
package spvm_pkg;

  // operation codes carried in tuser
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_MIX   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SAMPLE_COUNT = 2'd0;
  localparam logic [1:0] CFG_SPEED        = 2'd1;
  localparam logic [1:0] CFG_VOLUME       = 2'd2;
  localparam logic [1:0] CFG_LOOP         = 2'd3;

  localparam int IN_TDATA_W  = 80;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_PAD_W   = OUT_TDATA_W - 50;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 17;
  localparam int POS_W       = 17;
  localparam int MUL_W       = 18;

  localparam int GAIN_SHIFT_BLEND  = 9;
  localparam int GAIN_SHIFT_DIRECT = 10;
  localparam logic signed [27:0] MIX_SAT_HI = 28'sd32000;
  localparam logic signed [27:0] MIX_SAT_LO = -28'sd32000;

  typedef struct packed {
    logic [16:0] sample_count;
    logic [15:0] speed;
    logic [8:0]  volume;
    logic        loop_en;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    sample_count: 17'd0,
    speed:        16'd4096,
    volume:       9'd256,
    loop_en:      1'b0
  };

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] address;
    logic [15:0] sample_l;
    logic [15:0] sample_r;
    logic [15:0] mix_l;
    logic [15:0] mix_r;
  } item_t;

  typedef struct packed {
    logic [15:0] out_l;
    logic [15:0] out_r;
    logic        playing;
    logic [16:0] position;
  } result_t;

endpackage

// File: design/spvm_ram.sv
module spvm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/spvm_mul.sv
module spvm_mul (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [spvm_pkg::MUL_W-1:0]  a_i,
  input  logic signed [spvm_pkg::MUL_W-1:0]  b_i,
  output logic signed [2*spvm_pkg::MUL_W-1:0] p_o
);

  logic signed [2*spvm_pkg::MUL_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

// File: design/spvm_core.sv
module spvm_core #(
  parameter int ADDRESS_BITS  = 16,
  parameter int FRACTION_BITS = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  spvm_pkg::item_t   in_item_i,
  input  spvm_pkg::cfg_t    cfg_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output spvm_pkg::result_t res_o
);

  localparam int StoreDepthInt = 1 << ADDRESS_BITS;
  localparam logic [31:0] StoreDepth = 32'(StoreDepthInt);
  localparam logic [16:0] PhaseOne = 17'd1 << FRACTION_BITS;
  localparam int AdvW = 17 - FRACTION_BITS;
  localparam logic [36:0] FracMask = (37'd1 << FRACTION_BITS) - 37'd1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ADV  = 4'd1;
  localparam logic [3:0] S_RDC  = 4'd2;
  localparam logic [3:0] S_RDN  = 4'd3;
  localparam logic [3:0] S_CAPN = 4'd4;
  localparam logic [3:0] S_MBL  = 4'd5;
  localparam logic [3:0] S_MBR  = 4'd6;
  localparam logic [3:0] S_MGL  = 4'd7;
  localparam logic [3:0] S_MGR  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]  state_q, state_d;
  logic [16:0] pos_q, pos_d;
  logic [16:0] phase_q, phase_d;
  logic        active_q, active_d;

  logic        mixed_q, blend_q, mute_q;
  logic [15:0] mix_l_q, mix_r_q;
  logic [31:0] cur_q, nxt_q;
  logic [15:0] sl_q, sr_q, res_l_q;
  logic [15:0] res_r;

  logic        accept;
  logic [16:0] phase_sum, phase_m1, phase_new, pos_sum, nxt_idx;
  logic [AdvW-1:0] adv;
  logic        reduce, past_end;
  logic [31:0] wr_addr32, rd_idx32;
  logic        ram_we, ram_re;
  logic [31:0] ram_rdata;
  logic [8:0]  vol_eff;
  logic [16:0] diff_l, diff_r;
  logic        mul_en;
  logic signed [spvm_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*spvm_pkg::MUL_W-1:0] prod_s;
  logic [2*spvm_pkg::MUL_W-1:0]        prod;

  function automatic logic in_range_f(logic [16:0] idx, logic [16:0] count);
    return (idx < count) && (32'(idx) < StoreDepth);
  endfunction

  // a + (b - a) * phase / one, truncated toward zero
  function automatic logic [15:0] blend_f(logic [15:0] a, logic [35:0] p);
    logic signed [36:0] num;
    logic signed [36:0] q;
    num = ($signed({{21{a[15]}}, a}) <<< FRACTION_BITS) + $signed({p[35], p});
    q = num >>> FRACTION_BITS;
    if (num[36] && ((num[36:0] & FracMask) != 37'd0)) begin
      q = q + 37'sd1;
    end
    return q[15:0];
  endfunction

  // (mix * den + s * volume) / den, truncated toward zero, then saturated
  function automatic logic [15:0] mix_f(logic [15:0] mix, logic [35:0] p, logic half);
    logic signed [27:0] sum;
    logic signed [27:0] q;
    logic               rem;
    if (half) begin
      sum = ($signed({{12{mix[15]}}, mix}) <<< spvm_pkg::GAIN_SHIFT_BLEND) + $signed(p[27:0]);
      q   = sum >>> spvm_pkg::GAIN_SHIFT_BLEND;
      rem = |sum[spvm_pkg::GAIN_SHIFT_BLEND-1:0];
    end else begin
      sum = ($signed({{12{mix[15]}}, mix}) <<< spvm_pkg::GAIN_SHIFT_DIRECT) + $signed(p[27:0]);
      q   = sum >>> spvm_pkg::GAIN_SHIFT_DIRECT;
      rem = |sum[spvm_pkg::GAIN_SHIFT_DIRECT-1:0];
    end
    if (sum[27] && rem) begin
      q = q + 28'sd1;
    end
    if (q > spvm_pkg::MIX_SAT_HI) begin
      q = spvm_pkg::MIX_SAT_HI;
    end else if (q < spvm_pkg::MIX_SAT_LO) begin
      q = spvm_pkg::MIX_SAT_LO;
    end
    return q[15:0];
  endfunction

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign res_valid_o = (state_q == S_OUT);

  // phase step: reduce by whole samples while strictly above one
  assign phase_sum = phase_q + {1'b0, cfg_i.speed};
  assign phase_m1  = phase_sum - 17'd1;
  assign reduce    = phase_sum > PhaseOne;
  assign adv       = reduce ? phase_m1[16:FRACTION_BITS] : '0;
  assign phase_new = reduce ? ((phase_m1 & (PhaseOne - 17'd1)) + 17'd1) : phase_sum;
  assign pos_sum   = pos_q + 17'(adv);
  assign past_end  = pos_sum > cfg_i.sample_count;
  assign nxt_idx   = pos_q + 17'd1;

  // sample store
  assign wr_addr32 = 32'(in_item_i.address);
  assign ram_we    = accept && (in_item_i.op == spvm_pkg::OP_WRITE) && (wr_addr32 < StoreDepth);
  assign ram_re    = (state_q == S_RDC) || (state_q == S_RDN);
  assign rd_idx32  = (state_q == S_RDC) ? 32'(pos_q) : 32'(nxt_idx);

  spvm_ram #(
    .WIDTH(32),
    .DEPTH(StoreDepthInt)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wr_addr32[ADDRESS_BITS-1:0]),
    .wdata_i({in_item_i.sample_r, in_item_i.sample_l}),
    .re_i   (ram_re),
    .raddr_i(rd_idx32[ADDRESS_BITS-1:0]),
    .rdata_o(ram_rdata)
  );

  // shared multiplier: two blend products, then two gain products
  assign vol_eff = mute_q ? 9'd0 : cfg_i.volume;
  assign diff_l  = {nxt_q[15], nxt_q[15:0]} - {cur_q[15], cur_q[15:0]};
  assign diff_r  = {nxt_q[31], nxt_q[31:16]} - {cur_q[31], cur_q[31:16]};

  always_comb begin
    mul_en = 1'b1;
    unique case (state_q)
      S_MBL: begin
        mul_a = $signed({diff_l[16], diff_l});
        mul_b = $signed({1'b0, phase_q});
      end
      S_MBR: begin
        mul_a = $signed({diff_r[16], diff_r});
        mul_b = $signed({1'b0, phase_q});
      end
      S_MGL: begin
        mul_a = $signed({{2{sl_q[15]}}, sl_q});
        mul_b = $signed({9'd0, vol_eff});
      end
      S_MGR: begin
        mul_a = $signed({{2{sr_q[15]}}, sr_q});
        mul_b = $signed({9'd0, vol_eff});
      end
      default: begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
      end
    endcase
  end

  spvm_mul u_mul (
    .clk_i(clk_i),
    .en_i (mul_en),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (prod_s)
  );

  assign prod = prod_s;

  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    phase_d  = phase_q;
    active_d = active_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_item_i.op == spvm_pkg::OP_START) begin
            pos_d    = '0;
            active_d = 1'b1;
          end
          if ((in_item_i.op == spvm_pkg::OP_MIX) && active_q) begin
            state_d = S_ADV;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_ADV: begin
        phase_d = phase_new;
        pos_d   = pos_sum;
        if (past_end) begin
          if (cfg_i.loop_en) begin
            pos_d = '0;
          end else begin
            active_d = 1'b0;
          end
        end
        state_d = S_RDC;
      end
      S_RDC:  state_d = S_RDN;
      S_RDN:  state_d = S_CAPN;
      S_CAPN: state_d = S_MBL;
      S_MBL:  state_d = S_MBR;
      S_MBR:  state_d = S_MGL;
      S_MGL:  state_d = S_MGR;
      S_MGR:  state_d = S_OUT;
      S_OUT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pos_q    <= '0;
      phase_q  <= '0;
      active_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      phase_q  <= phase_d;
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mix_l_q <= in_item_i.mix_l;
      mix_r_q <= in_item_i.mix_r;
      mixed_q <= (in_item_i.op == spvm_pkg::OP_MIX) && active_q;
    end
    if (state_q == S_ADV) begin
      blend_q <= {1'b0, cfg_i.speed} < PhaseOne;
      mute_q  <= past_end && !cfg_i.loop_en;
    end
    if (state_q == S_RDN) begin
      cur_q <= in_range_f(pos_q, cfg_i.sample_count) ? ram_rdata : '0;
    end
    if (state_q == S_CAPN) begin
      nxt_q <= in_range_f(nxt_idx, cfg_i.sample_count) ? ram_rdata : '0;
    end
    if (state_q == S_MBR) begin
      sl_q <= blend_q ? blend_f(cur_q[15:0], prod) : cur_q[15:0];
    end
    if (state_q == S_MGL) begin
      sr_q <= blend_q ? blend_f(cur_q[31:16], prod) : cur_q[31:16];
    end
    if (state_q == S_MGR) begin
      res_l_q <= mix_f(mix_l_q, prod, blend_q);
    end
  end

  assign res_r = mix_f(mix_r_q, prod, blend_q);

  assign res_o.out_l    = mixed_q ? res_l_q : mix_l_q;
  assign res_o.out_r    = mixed_q ? res_r : mix_r_q;
  assign res_o.playing  = active_q;
  assign res_o.position = pos_q;

endmodule

// File: design/sample_playback_voice_mixer.sv
// one stereo sample-playback voice with linear interpolation
// input stream: tuser carries the operation (write sample, start, mix frame),
//   tdata carries address, left/right sample and the left/right frame to mix into
// output stream: one transaction per input transaction, in order, carrying the
//   mixed (or passed through) frame, the playing flag and the play position
// config channel: register index and data, always ready; write it only while
//   no transaction is in flight
// timing: write, start, unused operations and mix frames on an idle voice show
//   their result 2 cycles after acceptance; a mix frame on a playing voice
//   takes 10 cycles: phase step, two reads on the single store read port, and
//   four products on the one shared 18x18 multiplier
// the input is accepted one transaction at a time; the next one is taken as
//   soon as the result has moved into the output register
// a stalled output holds its transaction; one more result may finish and wait
//   inside the voice, after which the input stalls too
// reset: voice stopped at position 0, phase 0, registers at their defaults;
//   the sample store is not cleared
module sample_playback_voice_mixer #(
  parameter int ADDRESS_BITS  = 16,
  parameter int FRACTION_BITS = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // address, sample_left, sample_right, mix_left, mix_right
  input  logic [spvm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // operation
  input  logic [spvm_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // out_left, out_right, is_playing, play_position, zero pad
  output logic [spvm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [spvm_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [spvm_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  spvm_pkg::cfg_t    cfg_q;
  spvm_pkg::item_t   item;
  spvm_pkg::result_t res, out_q;
  logic              res_valid, res_ready;
  logic              out_valid_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= spvm_pkg::CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        spvm_pkg::CFG_SAMPLE_COUNT: cfg_q.sample_count <= cfg_data_i;
        spvm_pkg::CFG_SPEED:        cfg_q.speed        <= cfg_data_i[15:0];
        spvm_pkg::CFG_VOLUME:       cfg_q.volume       <= cfg_data_i[8:0];
        spvm_pkg::CFG_LOOP:         cfg_q.loop_en      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign item.op       = s_axis_tuser;
  assign item.address  = s_axis_tdata[15:0];
  assign item.sample_l = s_axis_tdata[31:16];
  assign item.sample_r = s_axis_tdata[47:32];
  assign item.mix_l    = s_axis_tdata[63:48];
  assign item.mix_r    = s_axis_tdata[79:64];

  spvm_core #(
    .ADDRESS_BITS (ADDRESS_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (item),
    .cfg_i      (cfg_q),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  // output register, refilled in the cycle it is emptied
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{spvm_pkg::OUT_PAD_W{1'b0}}, out_q.position, out_q.playing,
                          out_q.out_r, out_q.out_l};

endmodule

// File: design/spvm_checker.sv
module spvm_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [spvm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic       in_acc, out_acc;
  logic [1:0] pend_q, pend_d;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // transactions accepted but not yet delivered
  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("output valid during reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output transaction changed");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("input taken again right after a transaction");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (pend_q != 2'd0))
    else $error("result delivered without a pending transaction");

  a_bounded_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (pend_q != 2'd2))
    else $error("more than two transactions in flight");

endmodule

bind sample_playback_voice_mixer spvm_checker u_spvm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

// File: tb/tb_sample_playback_voice_mixer.sv
module tb_sample_playback_voice_mixer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS = 12;
  localparam int unsigned PHASE_ONE = 1 << FRAC_BITS;
  localparam int unsigned POS_MASK = 32'h1FFFF;
  localparam int unsigned MEM_DEPTH = 65536;
  localparam longint SAT = 32000;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int PHASES = 12;
  localparam int ITEMS_PER_PHASE = 110;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_CYCLES = 30;
  localparam longint TIMEOUT_NS = 64'd20_000_000;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [spvm_pkg::IN_TDATA_W-1:0] s_axis_tdata;
  logic [spvm_pkg::IN_TUSER_W-1:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [spvm_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [spvm_pkg::CFG_INDEX_W-1:0] cfg_index_i;
  logic [spvm_pkg::CFG_DATA_W-1:0] cfg_data_i;

  sample_playback_voice_mixer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // voice model: store, playback state and register copies
  bit [31:0] sample_mem [0:MEM_DEPTH-1];
  bit sample_loaded [0:MEM_DEPTH-1];
  int unsigned voice_pos = 0;
  int unsigned voice_phase = 0;
  bit voice_on = 1'b0;
  int unsigned reg_count = spvm_pkg::CFG_RESET.sample_count;
  int unsigned reg_speed = spvm_pkg::CFG_RESET.speed;
  int unsigned reg_volume = spvm_pkg::CFG_RESET.volume;
  bit reg_loop = spvm_pkg::CFG_RESET.loop_en;

  spvm_pkg::result_t due_frames[$];
  int misses = 0;
  int sent = 0;

  // idling control
  bit calm = 1'b0;
  int tx_idle_pct = 20;
  int rx_idle_pct = 20;
  bit long_hold_req = 1'b0;
  int stall_left = 0;

  typedef struct {
    bit is_cfg;
    logic [1:0] cfg_idx;
    int unsigned cfg_val;
    spvm_pkg::item_t it;
    bit typed;
    spvm_pkg::result_t res;
  } step_t;

  step_t script[$];

  function automatic logic [31:0] fetch(int unsigned idx);
    if (idx >= reg_count || idx >= MEM_DEPTH) return 32'd0;
    return sample_mem[idx];
  endfunction

  function automatic longint blend_chan(logic signed [15:0] a, logic signed [15:0] b,
                                        int unsigned ph);
    longint num;
    num = longint'(a) * longint'(PHASE_ONE) + (longint'(b) - longint'(a)) * longint'(ph);
    return num / longint'(PHASE_ONE);
  endfunction

  function automatic logic [15:0] mix_chan(logic signed [15:0] frame, longint s, longint den,
                                           int unsigned gain);
    longint q;
    q = (longint'(frame) * den + s * longint'(gain)) / den;
    if (q > SAT) q = SAT;
    if (q < -SAT) q = -SAT;
    return q[15:0];
  endfunction

  function automatic spvm_pkg::result_t voice_step(spvm_pkg::item_t it);
    spvm_pkg::result_t r;
    int unsigned adv;
    int unsigned gain;
    logic [31:0] cur;
    logic [31:0] nxt;
    r.out_l = it.mix_l;
    r.out_r = it.mix_r;
    case (it.op)
      spvm_pkg::OP_WRITE: begin
        sample_mem[it.address] = {it.sample_r, it.sample_l};
        sample_loaded[it.address] = 1'b1;
      end
      spvm_pkg::OP_START: begin
        voice_pos = 0;
        voice_on = 1'b1;
      end
      spvm_pkg::OP_MIX: begin
        if (voice_on) begin
          gain = reg_volume;
          adv = 0;
          voice_phase += reg_speed;
          // only a phase strictly above one is reduced
          if (voice_phase > PHASE_ONE) begin
            adv = (voice_phase - 1) >> FRAC_BITS;
            voice_phase -= adv << FRAC_BITS;
          end
          voice_pos = (voice_pos + adv) & POS_MASK;
          if (voice_pos > reg_count) begin
            if (reg_loop) begin
              voice_pos = 0;
            end else begin
              voice_on = 1'b0;
              gain = 0;
            end
          end
          cur = fetch(voice_pos);
          if (reg_speed < PHASE_ONE) begin
            nxt = fetch((voice_pos + 1) & POS_MASK);
            r.out_l = mix_chan(it.mix_l, blend_chan(cur[15:0], nxt[15:0], voice_phase),
                               512, gain);
            r.out_r = mix_chan(it.mix_r, blend_chan(cur[31:16], nxt[31:16], voice_phase),
                               512, gain);
          end else begin
            r.out_l = mix_chan(it.mix_l, longint'($signed(cur[15:0])), 1024, gain);
            r.out_r = mix_chan(it.mix_r, longint'($signed(cur[31:16])), 1024, gain);
          end
        end
      end
      default: ;
    endcase
    r.playing = voice_on;
    r.position = voice_pos[16:0];
    return r;
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 15))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic spvm_pkg::item_t rand_item(logic [1:0] op);
    spvm_pkg::item_t it;
    it.op = op;
    it.address = 16'($urandom);
    it.sample_l = rand_word();
    it.sample_r = rand_word();
    it.mix_l = rand_word();
    it.mix_r = rand_word();
    return it;
  endfunction

  function automatic void add_cfg(logic [1:0] idx, int unsigned val);
    step_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.cfg_idx = idx;
    s.cfg_val = val;
    script.push_back(s);
  endfunction

  function automatic void add_row(logic [1:0] op, logic [15:0] addr, logic [15:0] sl,
                                  logic [15:0] sr, logic [15:0] ml, logic [15:0] mr,
                                  bit typed, logic [15:0] want_l, logic [15:0] want_r,
                                  bit want_on, logic [16:0] want_pos);
    step_t s;
    s = '{default: '0};
    s.it = '{op: op, address: addr, sample_l: sl, sample_r: sr, mix_l: ml, mix_r: mr};
    s.typed = typed;
    s.res = '{out_l: want_l, out_r: want_r, playing: want_on, position: want_pos};
    script.push_back(s);
  endfunction

  function automatic void flag_miss(string what, int want, int got);
    misses++;
    if (misses <= 10) $display("mismatch in %s: expected %0d, got %0d", what, want, got);
  endfunction

  // drop valid and wait until every outstanding frame has come back
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (due_frames.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] idx, int unsigned val);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[spvm_pkg::CFG_DATA_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      spvm_pkg::CFG_SAMPLE_COUNT: reg_count = val & POS_MASK;
      spvm_pkg::CFG_SPEED:        reg_speed = val & 32'hFFFF;
      spvm_pkg::CFG_VOLUME:       reg_volume = val & 32'h1FF;
      spvm_pkg::CFG_LOOP:         reg_loop = val[0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic push_item(spvm_pkg::item_t it, bit typed, spvm_pkg::result_t fixed);
    spvm_pkg::result_t want;
    if (!calm && $urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    want = voice_step(it);
    if (typed) want = fixed;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.op;
    s_axis_tdata <= {it.mix_r, it.mix_l, it.sample_r, it.sample_l, it.address};
    do @(posedge clk_i); while (!s_axis_tready);
    due_frames.push_back(want);
    sent++;
  endtask

  // load every entry the coming frame will read that is in range but still empty
  task automatic fill_ahead();
    int unsigned ph;
    int unsigned adv;
    int unsigned p;
    int unsigned reads[2];
    int n;
    spvm_pkg::item_t w;
    if (!voice_on) return;
    ph = voice_phase + reg_speed;
    adv = 0;
    if (ph > PHASE_ONE) adv = (ph - 1) >> FRAC_BITS;
    p = (voice_pos + adv) & POS_MASK;
    if (p > reg_count) begin
      if (!reg_loop) return;
      p = 0;
    end
    reads[0] = p;
    reads[1] = (p + 1) & POS_MASK;
    n = (reg_speed < PHASE_ONE) ? 2 : 1;
    for (int i = 0; i < n; i++) begin
      if (reads[i] < reg_count && reads[i] < MEM_DEPTH && !sample_loaded[reads[i]]) begin
        w = rand_item(spvm_pkg::OP_WRITE);
        w.address = reads[i][15:0];
        push_item(w, 1'b0, '0);
      end
    end
  endtask

  task automatic offer(spvm_pkg::item_t it, bit typed, spvm_pkg::result_t fixed);
    if (it.op == spvm_pkg::OP_MIX) fill_ahead();
    push_item(it, typed, fixed);
  endtask

  // receiver: random stall bursts, plus one long hold on request
  always @(posedge clk_i) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      stall_left = LONG_HOLD;
    end else if (stall_left == 0 && !calm && $urandom_range(0, 99) < rx_idle_pct) begin
      stall_left = $urandom_range(1, 10);
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : frame_check
    spvm_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (due_frames.size() == 0) begin
        flag_miss("frame with nothing outstanding, position", 0,
                  int'(m_axis_tdata[49:33]));
      end else begin
        want = due_frames.pop_front();
        if (m_axis_tdata[15:0] !== want.out_l)
          flag_miss("out_left", int'($signed(want.out_l)), int'($signed(m_axis_tdata[15:0])));
        if (m_axis_tdata[31:16] !== want.out_r)
          flag_miss("out_right", int'($signed(want.out_r)),
                    int'($signed(m_axis_tdata[31:16])));
        if (m_axis_tdata[32] !== want.playing)
          flag_miss("is_playing", int'(want.playing), int'(m_axis_tdata[32]));
        if (m_axis_tdata[49:33] !== want.position)
          flag_miss("play_position", int'(want.position), int'(m_axis_tdata[49:33]));
        if (m_axis_tdata[spvm_pkg::OUT_TDATA_W-1:50] !== '0)
          flag_miss("tdata pad", 0, int'(m_axis_tdata[spvm_pkg::OUT_TDATA_W-1:50]));
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    spvm_pkg::item_t it;
    int roll;
    int unsigned cnt;
    int base;
    int k;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;

    // idle voice, unused operation, store writes at the address extremes, start
    add_row(spvm_pkg::OP_MIX, 0, 0, 0, -32768, 32767, 1, -32768, 32767, 0, 0);
    add_row(OP_UNUSED, 16'hFFFF, 16'h8000, 16'h7FFF, 32767, -32768, 1, 32767, -32768, 0, 0);
    add_row(spvm_pkg::OP_WRITE, 0, -32768, 32767, 100, -100, 1, 100, -100, 0, 0);
    add_row(spvm_pkg::OP_WRITE, 1, 32767, -32768, 0, 0, 1, 0, 0, 0, 0);
    add_row(spvm_pkg::OP_WRITE, 2, 16'h5A5A, 16'hA5A5, -1, 1, 1, -1, 1, 0, 0);
    add_row(spvm_pkg::OP_WRITE, 3, -1, 1, 16'h1234, 16'hEDCB, 1, 16'h1234, 16'hEDCB, 0, 0);
    add_row(spvm_pkg::OP_WRITE, 16'hFFFF, 12345, -12345, 5, 5, 1, 5, 5, 0, 0);
    add_row(spvm_pkg::OP_START, 0, 0, 0, 7, -7, 1, 7, -7, 1, 0);
    // empty store: phase lands exactly on one, then the stop frame, then idle passthrough
    add_row(spvm_pkg::OP_MIX, 0, 0, 0, 32767, -32768, 1, 32000, -32000, 1, 0);
    add_row(spvm_pkg::OP_MIX, 0, 0, 0, 32767, -32768, 1, 32000, -32000, 0, 1);
    add_row(spvm_pkg::OP_MIX, 0, 0, 0, 32767, -32768, 1, 32767, -32768, 0, 1);
    add_cfg(spvm_pkg::CFG_SAMPLE_COUNT, 4);
    add_row(spvm_pkg::OP_START, 0, 0, 0, 5, 6, 1, 5, 6, 1, 0);
    repeat (5) add_row(spvm_pkg::OP_MIX, 0, 0, 0, 20000, -20000, 0, 0, 0, 0, 0);
    add_cfg(spvm_pkg::CFG_SPEED, 2048);
    add_cfg(spvm_pkg::CFG_LOOP, 1);
    add_cfg(spvm_pkg::CFG_VOLUME, 0);
    add_row(spvm_pkg::OP_START, 0, 0, 0, 1, 2, 1, 1, 2, 1, 0);
    repeat (2) add_row(spvm_pkg::OP_MIX, 0, 0, 0, -300, 300, 0, 0, 0, 0, 0);
    add_cfg(spvm_pkg::CFG_VOLUME, 256);
    add_cfg(spvm_pkg::CFG_SPEED, 65535);
    add_row(spvm_pkg::OP_START, 0, 0, 0, 0, 0, 1, 0, 0, 1, 0);
    repeat (2) add_row(spvm_pkg::OP_MIX, 0, 0, 0, 1000, -1000, 0, 0, 0, 0, 0);
    add_cfg(spvm_pkg::CFG_SAMPLE_COUNT, 65536);
    add_cfg(spvm_pkg::CFG_SPEED, 0);
    add_row(spvm_pkg::OP_START, 0, 0, 0, 0, 0, 1, 0, 0, 1, 0);
    repeat (2) add_row(spvm_pkg::OP_MIX, 0, 0, 0, -32768, 32767, 0, 0, 0, 0, 0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      if (script[i].is_cfg) cfg_write(script[i].cfg_idx, script[i].cfg_val);
      else offer(script[i].it, script[i].typed, script[i].res);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      calm = (ph == PHASES - 1);
      tx_idle_pct = (ph % 3 == 0) ? 0 : $urandom_range(5, 40);
      rx_idle_pct = (ph % 4 == 1) ? 0 : $urandom_range(5, 40);
      case ($urandom_range(0, 4))
        0: cnt = 0;
        1: cnt = 1;
        2: cnt = $urandom_range(2, 40);
        3: cnt = 65536;
        default: cnt = $urandom_range(0, 65536);
      endcase
      cfg_write(spvm_pkg::CFG_SAMPLE_COUNT, cnt);
      case ($urandom_range(0, 7))
        0: cfg_write(spvm_pkg::CFG_SPEED, 0);
        1: cfg_write(spvm_pkg::CFG_SPEED, PHASE_ONE - 1);
        2: cfg_write(spvm_pkg::CFG_SPEED, PHASE_ONE);
        3: cfg_write(spvm_pkg::CFG_SPEED, PHASE_ONE + 1);
        4: cfg_write(spvm_pkg::CFG_SPEED, 65535);
        5: cfg_write(spvm_pkg::CFG_SPEED, $urandom_range(1, PHASE_ONE - 1));
        6: cfg_write(spvm_pkg::CFG_SPEED, $urandom_range(PHASE_ONE + 1, 20000));
        default: cfg_write(spvm_pkg::CFG_SPEED, $urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 2))
        0: cfg_write(spvm_pkg::CFG_VOLUME, 0);
        1: cfg_write(spvm_pkg::CFG_VOLUME, 256);
        default: cfg_write(spvm_pkg::CFG_VOLUME, $urandom_range(0, 256));
      endcase
      cfg_write(spvm_pkg::CFG_LOOP, $urandom_range(0, 1));

      // every transaction counts toward the phase, including preload writes
      base = sent;
      offer(rand_item(spvm_pkg::OP_START), 1'b0, '0);
      k = 0;
      while (sent - base < ITEMS_PER_PHASE) begin
        // fill the block while the output is held
        if (ph == 3 && k == 20) long_hold_req = 1'b1;
        // sender holds back until the block has drained
        if (ph == 5 && k == 30) settle();
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
          it = rand_item(spvm_pkg::OP_START);
        end else if (roll < 14) begin
          it = rand_item(spvm_pkg::OP_WRITE);
          if ($urandom_range(0, 1) && reg_count > 0)
            it.address = 16'($urandom_range(0, (reg_count > 65535) ? 65535 : reg_count));
        end else if (roll < 17) begin
          it = rand_item(OP_UNUSED);
        end else begin
          it = rand_item(spvm_pkg::OP_MIX);
        end
        offer(it, 1'b0, '0);
        k++;
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (misses == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
